// ===== hw/rtl/wvm_pkg.sv =====
package wvm_pkg;

    localparam int VOICES_DEF       = 16;
    localparam int SAMPLE_WORDS_DEF = 65536;
    localparam int POS_W            = 18;
    localparam logic [POS_W-1:0] POS_MAX = 18'h3FFFF;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_RENDER = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  voice;
        logic [15:0] addr;
        logic [15:0] mem_word;
        logic [17:0] sample_count;
        logic [16:0] loop_start;
        logic        loop_on;
        logic        sixteen_bit;
        logic [23:0] phase_step;
        logic [6:0]  volume;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] mix_sample;
        logic [15:0]        playing_mask;
    } out_item_t;

    typedef struct packed {
        logic [15:0] base;
        logic [17:0] len;
        logic [16:0] loop_pt;
        logic        loops;
        logic        wide;
        logic [23:0] step;
        logic [6:0]  gain;
    } voice_cfg_t;

    typedef struct packed {
        logic [17:0] pos;
        logic [15:0] frac;
    } voice_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SET_WB,
        ST_V_SEL,
        ST_V_CHECK,
        ST_V_DIV,
        ST_V_RD0,
        ST_V_RD1,
        ST_V_CAP1,
        ST_V_MUL,
        ST_V_GAIN,
        ST_V_ACC,
        ST_DONE
    } state_t;

    // word to signed 16-bit sample; 8-bit samples land in the high byte
    function automatic logic signed [15:0] decode_sample(input logic [15:0] w,
                                                         input logic wide,
                                                         input logic hi);
        logic [7:0] b;
        b = hi ? w[15:8] : w[7:0];
        return wide ? $signed(w) : $signed({b, 8'h00});
    endfunction

endpackage

// ===== hw/rtl/wavetable_voice_mixer.sv =====
// Channel | Signals                      | Carries
// in      | in_valid, in_ready, in_item  | op plus voice/sample payload
// out     | out_valid, out_ready, out_item | mixed sample and active mask (render only)
//
// Write, start and stop ops complete on acceptance; set step/volume is a
// read-modify-write of the voice config memory (IDLE, then SET_WB).
// Render walks the voices one at a time: an idle voice is skipped in V_SEL; a
// playing voice passes V_CHECK, V_DIV only if its position wraps (serial
// remainder unit), then RD0, RD1, CAP1, MUL, GAIN and ACC; DONE closes the walk
// and loads the output. Each voice that is mixed makes two reads of the sample
// memory read port.
// Reset clears the active mask and control only; memories need no clearing.
// A finished frame waits in the output register; non-render ops keep flowing.
module wavetable_voice_mixer #(
    parameter int VOICES       = wvm_pkg::VOICES_DEF,
    parameter int SAMPLE_WORDS = wvm_pkg::SAMPLE_WORDS_DEF // power of two
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wvm_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output wvm_pkg::out_item_t out_item
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int AW = $clog2(SAMPLE_WORDS);

    // memories
    wvm_pkg::voice_cfg_t   cfg_mem [VOICES];
    wvm_pkg::voice_phase_t ph_mem  [VOICES];
    logic [15:0]           smem    [SAMPLE_WORDS];

    wvm_pkg::voice_cfg_t   cfg_q, cfg_wdata;
    wvm_pkg::voice_phase_t ph_q, ph_wdata;
    logic [15:0]           smem_q;

    wvm_pkg::state_t state_reg, state_next;

    logic [VOICES-1:0] active_reg, active_next;
    logic [CW-1:0]     vidx_reg, vidx_next;
    logic              out_valid_reg, out_valid_next;
    wvm_pkg::out_item_t out_reg;

    logic [VW-1:0] set_voice_reg;
    logic [23:0]   set_step_reg;
    logic [6:0]    set_gain_reg;

    logic [17:0]        pos_reg;
    logic [17:0]        i1_reg;
    logic               sel0_reg, sel1_reg;
    logic signed [15:0] s0_reg;
    logic signed [16:0] diff_reg;
    logic signed [33:0] prod_reg;
    logic signed [24:0] scaled_reg;
    logic signed [21:0] acc_reg;

    // control
    logic          accept;
    logic          voice_ok;
    logic          cfg_rd, ph_rd, cfg_we, ph_we, smem_rd, smem_we;
    logic [VW-1:0] cfg_ra, ph_wa, cfg_wa;
    logic [AW-1:0] smem_ra;
    logic [VW-1:0] vidx;

    // datapath helpers
    logic              can_loop;
    logic              div_start, div_done;
    logic [17:0]       div_rem;
    logic [AW-1:0]     word0, word1;
    logic              hi0, hi1;
    logic [18:0]       i1_wide;
    logic [17:0]       i1_calc;
    logic [24:0]       frac_sum;
    logic [18:0]       pos_adv;
    logic signed [16:0] interp;
    logic signed [15:0] s1_dec;
    logic signed [21:0] sat_in;

    assign accept   = in_valid && in_ready;
    assign voice_ok = (5'(in_item.voice) < 5'(VOICES));
    assign vidx     = vidx_reg[VW-1:0];
    assign can_loop = cfg_q.loops && (cfg_q.len > {1'b0, cfg_q.loop_pt});

    // sample word address and byte lane for a sample index
    function automatic logic [AW:0] sample_addr(input logic [15:0] base,
                                                input logic wide,
                                                input logic [17:0] idx);
        logic [17:0] ws;
        logic [18:0] bs;
        ws = {2'b00, base} + idx;
        bs = {base, 1'b0} + {1'b0, idx};
        return wide ? {ws[AW-1:0], 1'b0} : {bs[AW:1], bs[0]};
    endfunction

    assign {word0, hi0} = sample_addr(cfg_q.base, cfg_q.wide, pos_reg);
    assign {word1, hi1} = sample_addr(cfg_q.base, cfg_q.wide, i1_reg);

    assign i1_wide = {1'b0, pos_reg} + 19'd1;
    assign i1_calc = (i1_wide >= {1'b0, cfg_q.len}) ?
                     (can_loop ? {1'b0, cfg_q.loop_pt} : pos_reg) : i1_wide[17:0];

    assign frac_sum = {9'd0, ph_q.frac} + {1'b0, cfg_q.step};
    assign pos_adv  = {1'b0, pos_reg} + {10'd0, frac_sum[24:16]};

    assign s1_dec = wvm_pkg::decode_sample(smem_q, cfg_q.wide, sel1_reg);
    assign interp = 17'(s0_reg) + prod_reg[32:16];
    assign sat_in = acc_reg;

    // wrap remainder: (pos - loop) mod (len - loop)
    assign div_start = (state_reg == wvm_pkg::ST_V_CHECK) && (cfg_q.len != '0)
                       && (ph_q.pos >= cfg_q.len) && can_loop;

    wvm_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ph_q.pos - {1'b0, cfg_q.loop_pt}),
        .divisor  (cfg_q.len - {1'b0, cfg_q.loop_pt}),
        .done     (div_done),
        .rem      (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wvm_pkg::ST_IDLE:
            begin
                if (accept && in_item.op == wvm_pkg::OP_SET && voice_ok)
                    state_next = wvm_pkg::ST_SET_WB;
                else if (accept && in_item.op == wvm_pkg::OP_RENDER)
                    state_next = wvm_pkg::ST_V_SEL;
            end
            wvm_pkg::ST_SET_WB: state_next = wvm_pkg::ST_IDLE;
            wvm_pkg::ST_V_SEL:
            begin
                if (vidx_reg == CW'(VOICES))
                    state_next = wvm_pkg::ST_DONE;
                else if (active_reg[vidx])
                    state_next = wvm_pkg::ST_V_CHECK;
            end
            wvm_pkg::ST_V_CHECK:
            begin
                if (cfg_q.len == '0 || (ph_q.pos >= cfg_q.len && !can_loop))
                    state_next = wvm_pkg::ST_V_SEL;
                else if (ph_q.pos >= cfg_q.len)
                    state_next = wvm_pkg::ST_V_DIV;
                else
                    state_next = wvm_pkg::ST_V_RD0;
            end
            wvm_pkg::ST_V_DIV:
            begin
                if (div_done)
                    state_next = wvm_pkg::ST_V_RD0;
            end
            wvm_pkg::ST_V_RD0:  state_next = wvm_pkg::ST_V_RD1;
            wvm_pkg::ST_V_RD1:  state_next = wvm_pkg::ST_V_CAP1;
            wvm_pkg::ST_V_CAP1: state_next = wvm_pkg::ST_V_MUL;
            wvm_pkg::ST_V_MUL:  state_next = wvm_pkg::ST_V_GAIN;
            wvm_pkg::ST_V_GAIN: state_next = wvm_pkg::ST_V_ACC;
            wvm_pkg::ST_V_ACC:  state_next = wvm_pkg::ST_V_SEL;
            wvm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = wvm_pkg::ST_IDLE;
            end
            default: state_next = wvm_pkg::ST_IDLE;
        endcase
    end

    // memory port controls and handshake
    always_comb
    begin
        in_ready  = 1'b0;
        cfg_rd    = 1'b0;
        ph_rd     = 1'b0;
        cfg_we    = 1'b0;
        ph_we     = 1'b0;
        smem_rd   = 1'b0;
        smem_we   = 1'b0;
        cfg_ra    = vidx;
        cfg_wa    = in_item.voice[VW-1:0];
        ph_wa     = in_item.voice[VW-1:0];
        smem_ra   = word0;
        cfg_wdata = '{base: in_item.addr, len: in_item.sample_count,
                      loop_pt: in_item.loop_start, loops: in_item.loop_on,
                      wide: in_item.sixteen_bit, step: in_item.phase_step,
                      gain: in_item.volume};
        ph_wdata  = '0;
        case (state_reg)
            wvm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                smem_we  = accept && in_item.op == wvm_pkg::OP_WRITE;
                cfg_we   = accept && in_item.op == wvm_pkg::OP_START && voice_ok;
                ph_we    = cfg_we;
                cfg_rd   = accept && in_item.op == wvm_pkg::OP_SET && voice_ok;
                cfg_ra   = in_item.voice[VW-1:0];
            end
            wvm_pkg::ST_SET_WB:
            begin
                cfg_we    = 1'b1;
                cfg_wa    = set_voice_reg;
                cfg_wdata = cfg_q;
                cfg_wdata.step = set_step_reg;
                cfg_wdata.gain = set_gain_reg;
            end
            wvm_pkg::ST_V_SEL:
            begin
                cfg_rd = (vidx_reg != CW'(VOICES)) && active_reg[vidx];
                ph_rd  = cfg_rd;
            end
            wvm_pkg::ST_V_RD0:
            begin
                smem_rd = 1'b1;
                smem_ra = word0;
            end
            wvm_pkg::ST_V_RD1:
            begin
                smem_rd = 1'b1;
                smem_ra = word1;
            end
            wvm_pkg::ST_V_GAIN:
            begin
                ph_we    = 1'b1;
                ph_wa    = vidx;
                ph_wdata.pos  = pos_adv[18] ? wvm_pkg::POS_MAX : pos_adv[17:0];
                ph_wdata.frac = frac_sum[15:0];
            end
            default: ;
        endcase
    end

    // memories: synchronous (registered) reads
    always_ff @(posedge clk)
    begin
        if (cfg_we)
            cfg_mem[cfg_wa] <= cfg_wdata;
        if (cfg_rd)
            cfg_q <= cfg_mem[cfg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ph_we)
            ph_mem[ph_wa] <= ph_wdata;
        if (ph_rd)
            ph_q <= ph_mem[vidx];
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
            smem[in_item.addr[AW-1:0]] <= in_item.mem_word;
        if (smem_rd)
            smem_q <= smem[smem_ra];
    end

    // control registers
    always_comb
    begin
        active_next    = active_reg;
        vidx_next      = vidx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept && voice_ok && in_item.op == wvm_pkg::OP_START)
            active_next[in_item.voice[VW-1:0]] = 1'b1;
        if (accept && voice_ok && in_item.op == wvm_pkg::OP_STOP)
            active_next[in_item.voice[VW-1:0]] = 1'b0;
        case (state_reg)
            wvm_pkg::ST_IDLE: vidx_next = '0;
            wvm_pkg::ST_V_SEL:
            begin
                if (vidx_reg != CW'(VOICES) && !active_reg[vidx])
                    vidx_next = vidx_reg + 1'b1;
            end
            wvm_pkg::ST_V_CHECK:
            begin
                if (cfg_q.len == '0)
                    vidx_next = vidx_reg + 1'b1;
                else if (ph_q.pos >= cfg_q.len && !can_loop)
                begin
                    active_next[vidx] = 1'b0;
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            wvm_pkg::ST_V_ACC: vidx_next = vidx_reg + 1'b1;
            wvm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wvm_pkg::ST_IDLE;
            active_reg    <= '0;
            vidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            vidx_reg      <= vidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == wvm_pkg::ST_IDLE && accept)
        begin
            set_voice_reg <= in_item.voice[VW-1:0];
            set_step_reg  <= in_item.phase_step;
            set_gain_reg  <= in_item.volume;
            acc_reg       <= '0;
        end
        case (state_reg)
            wvm_pkg::ST_V_CHECK: pos_reg <= ph_q.pos;
            wvm_pkg::ST_V_DIV:
            begin
                if (div_done)
                    pos_reg <= {1'b0, cfg_q.loop_pt} + div_rem;
            end
            wvm_pkg::ST_V_RD0:
            begin
                sel0_reg <= hi0;
                i1_reg   <= i1_calc;
            end
            wvm_pkg::ST_V_RD1:
            begin
                sel1_reg <= hi1;
                s0_reg   <= wvm_pkg::decode_sample(smem_q, cfg_q.wide, sel0_reg);
            end
            wvm_pkg::ST_V_CAP1: diff_reg <= 17'(s1_dec) - 17'(s0_reg);
            wvm_pkg::ST_V_MUL:  prod_reg <= 34'(diff_reg) * $signed({18'd0, ph_q.frac});
            wvm_pkg::ST_V_GAIN: scaled_reg <= 25'(interp) * $signed({18'd0, cfg_q.gain});
            wvm_pkg::ST_V_ACC:  acc_reg <= acc_reg + 22'($signed(scaled_reg[24:7]));
            wvm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (sat_in > 22'sd32767)
                        out_reg.mix_sample <= 16'sh7FFF;
                    else if (sat_in < -22'sd32768)
                        out_reg.mix_sample <= 16'sh8000;
                    else
                        out_reg.mix_sample <= sat_in[15:0];
                    out_reg.playing_mask <= 16'(active_reg);
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== hw/rtl/wvm_mod_unit.sv =====
// Serial restoring remainder, one dividend bit per cycle.
module wvm_mod_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [wvm_pkg::POS_W-1:0]      dividend,
    input  logic [wvm_pkg::POS_W-1:0]      divisor,
    output logic                           done,
    output logic [wvm_pkg::POS_W-1:0]      rem
);
    localparam int W  = wvm_pkg::POS_W;
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    trial;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[W-1]};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(W);
            rem_next = '0;
            dvd_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
                rem_next = W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done = (cnt_reg == CW'(1));
    assign rem  = rem_next;

endmodule

// ===== hw/rtl/wvm_checker.sv =====
module wvm_checker #(
    parameter int VOICES = wvm_pkg::VOICES_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input wvm_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_ready,
    input wvm_pkg::out_item_t out_item
);
    logic [16:0] live_mask;
    assign live_mask = (17'd1 << VOICES) - 17'd1;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped or changed while stalled");

    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.playing_mask & ~live_mask[15:0]) == 16'd0)
        else $error("active mask names a voice that does not exist");

    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.op == wvm_pkg::OP_RENDER |=> !in_ready)
        else $error("item taken while a frame renders");

    a_simple_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.op != wvm_pkg::OP_RENDER
        && in_item.op != wvm_pkg::OP_SET |=> in_ready)
        else $error("single-cycle op stalled the input");

endmodule

bind wavetable_voice_mixer wvm_checker #(.VOICES(VOICES)) u_wvm_checker (.*);

// ===== test/tb.sv =====
module tb;

    // one queued input item with its predicted frame, if any
    typedef struct {
        wvm_pkg::in_item_t  item;
        bit                 has_frame;
        wvm_pkg::out_item_t frame;
        bit                 drain;   // wait for all frames before sending
        bit                 calm;    // no idling from here on
    } job_t;

    localparam int NV        = wvm_pkg::VOICES_DEF;
    localparam int N_ITEMS   = 550;
    localparam int MAX_CYC   = 2_000_000;
    localparam int TAIL_CYC  = 600;   // tail after the last expected frame, to catch stray ones
    localparam int MAX_MISS  = 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    wvm_pkg::in_item_t  in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    wvm_pkg::out_item_t out_item;

    wavetable_voice_mixer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: sample memory with a written map, voice state
    // ---------------------------------------------------------------
    logic [15:0] smem [65536];
    bit          mem_ok [65536];
    bit          v_on [NV];
    logic [15:0] v_base [NV];
    logic [17:0] v_len [NV];
    logic [16:0] v_loop [NV];
    bit          v_loops [NV];
    bit          v_wide [NV];
    logic [17:0] v_pos [NV];
    logic [15:0] v_frac [NV];
    logic [23:0] v_step [NV];
    logic [6:0]  v_gain [NV];
    logic [15:0] unwritten_hit;   // voices that touched unwritten memory

    job_t               pending_q [$];
    wvm_pkg::out_item_t frames_due [$];
    job_t               cur_job;
    int                 miss_cnt = 0;
    int                 fail_cnt = 0;
    int                 cyc = 0;

    // Signed sample at index idx of voice v; 8-bit data lands in the high byte.
    function automatic int sample_at(int v, int unsigned idx);
        int unsigned b;
        int unsigned w;
        logic [15:0] d;
        logic [7:0]  by;
        b = v_base[v] * 2 + idx;
        w = v_wide[v] ? (v_base[v] + idx) % 65536 : (b >> 1) % 65536;
        if (!mem_ok[w])
            unwritten_hit[v] = 1'b1;
        d = smem[w];
        if (v_wide[v])
            return int'($signed(d));
        by = b[0] ? d[15:8] : d[7:0];
        return int'($signed(by)) * 256;
    endfunction

    // One voice's contribution to a frame; advances its phase.
    function automatic int voice_out(int v);
        int unsigned len, lp, pos, nxt, frac;
        bit          wraps;
        int          s0, s1;
        longint      s;
        len   = v_len[v];
        lp    = v_loop[v];
        pos   = v_pos[v];
        wraps = v_loops[v] && len > lp;
        if (len == 0)
            return 0;
        if (pos >= len)
        begin
            if (wraps)
                pos = lp + (pos - lp) % (len - lp);
            else
            begin
                v_on[v] = 1'b0;
                return 0;
            end
        end
        nxt = pos + 1;
        if (nxt >= len)
            nxt = wraps ? lp : pos;
        s0   = sample_at(v, pos);
        s1   = sample_at(v, nxt);
        frac = v_frac[v];
        // arithmetic shifts floor toward minus infinity
        s = longint'(s0) + ((longint'(s1 - s0) * longint'(frac)) >>> 16);
        s = (s * longint'(v_gain[v])) >>> 7;
        frac = frac + v_step[v];
        pos  = pos + (frac >> 16);
        if (pos > wvm_pkg::POS_MAX)
            pos = wvm_pkg::POS_MAX;
        v_pos[v]  = pos[17:0];
        v_frac[v] = frac[15:0];
        return int'(s);
    endfunction

    function automatic wvm_pkg::out_item_t mix_frame();
        int                 acc;
        wvm_pkg::out_item_t r;
        acc = 0;
        r   = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (v_on[i])
                acc += voice_out(i);
            if (v_on[i])
                r.playing_mask[i] = 1'b1;
        end
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        r.mix_sample = acc[15:0];
        return r;
    endfunction

    // Run one item through the predictor and queue it for the driver.
    task automatic add_job(wvm_pkg::in_item_t it, bit drain, bit calm);
        job_t j;
        j.item      = it;
        j.has_frame = 1'b0;
        j.frame     = '0;
        j.drain     = drain;
        j.calm      = calm;
        case (it.op)
            wvm_pkg::OP_WRITE:
            begin
                smem[it.addr]   = it.mem_word;
                mem_ok[it.addr] = 1'b1;
            end
            wvm_pkg::OP_START:
            begin
                v_base[it.voice]  = it.addr;
                v_len[it.voice]   = it.sample_count;
                v_loop[it.voice]  = it.loop_start;
                v_loops[it.voice] = it.loop_on;
                v_wide[it.voice]  = it.sixteen_bit;
                v_pos[it.voice]   = '0;
                v_frac[it.voice]  = '0;
                v_on[it.voice]    = 1'b1;
                v_step[it.voice]  = it.phase_step;
                v_gain[it.voice]  = it.volume;
            end
            wvm_pkg::OP_STOP:
                v_on[it.voice] = 1'b0;
            wvm_pkg::OP_SET:
            begin
                v_step[it.voice] = it.phase_step;
                v_gain[it.voice] = it.volume;
            end
            wvm_pkg::OP_RENDER:
            begin
                j.has_frame = 1'b1;
                j.frame     = mix_frame();
            end
            default: ;
        endcase
        pending_q.push_back(j);
    endtask

    function automatic wvm_pkg::in_item_t noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(wvm_pkg::in_item_t)-1:0];
    endfunction

    // Render, but first stop any voice that would read unwritten memory.
    task automatic add_render(bit drain, bit calm);
        bit                 on_s [NV];
        logic [17:0]        pos_s [NV];
        logic [15:0]        frac_s [NV];
        wvm_pkg::out_item_t dummy;
        wvm_pkg::in_item_t  it;
        on_s   = v_on;
        pos_s  = v_pos;
        frac_s = v_frac;
        unwritten_hit = '0;
        dummy  = mix_frame();
        v_on   = on_s;
        v_pos  = pos_s;
        v_frac = frac_s;
        for (int i = 0; i < NV; i++)
        begin
            if (unwritten_hit[i])
            begin
                it       = noise_item();
                it.op    = wvm_pkg::OP_STOP;
                it.voice = 4'(i);
                add_job(it, 1'b0, calm);
            end
        end
        it    = noise_item();
        it.op = wvm_pkg::OP_RENDER;
        add_job(it, drain, calm);
    endtask

    // Start a voice, mostly short and mostly over memory that has been written.
    task automatic add_start(bit calm);
        wvm_pkg::in_item_t it;
        bit                good;
        int unsigned       last;
        it    = noise_item();
        it.op = wvm_pkg::OP_START;
        if ($urandom_range(0, 9) == 0)
        begin
            // long voice: the render guard stops it before it strays
            it.sample_count = 18'($urandom_range(0, 131072));
            it.addr         = $urandom_range(0, 1) ? 16'd0 : 16'hFFF8;
        end
        else
        begin
            good = 1'b0;
            for (int t = 0; t < 8 && !good; t++)
            begin
                it.addr         = $urandom_range(0, 3) == 0
                                  ? 16'(16'hFFF0 + $urandom_range(0, 15))
                                  : 16'($urandom_range(0, 300));
                it.sample_count = 18'($urandom_range(0, 40));
                last = it.sample_count == 0 ? 0 :
                       (it.sixteen_bit ? it.sample_count - 1 : (it.sample_count - 1) / 2);
                good = 1'b1;
                for (int unsigned k = 0; k <= last; k++)
                    if (!mem_ok[(it.addr + k) % 65536])
                        good = 1'b0;
            end
            if (!good)
            begin
                it.addr         = 16'd0;
                it.sample_count = 18'($urandom_range(0, 16));
            end
            it.loop_start = $urandom_range(0, 3) == 0 ? it.loop_start
                                                      : 17'($urandom_range(0, it.sample_count));
        end
        if ($urandom_range(0, 3) != 0)
            it.phase_step = 24'($urandom_range(0, 24'h3FFFF));
        add_job(it, 1'b0, calm);
    endtask

    // ---------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ---------------------------------------------------------------
    logic took = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    bit   calm_now = 1'b0;

    always @(negedge clk)
    begin
        logic nv;
        job_t j;
        if (rst_n)
        begin
            nv = in_valid;
            if (!in_valid || took)
            begin
                nv = 1'b0;
                if (in_gap > 0)
                    in_gap--;
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && frames_due.size() > 0))
                begin
                    j        = pending_q.pop_front();
                    cur_job  = j;
                    calm_now = j.calm;
                    in_item <= j.item;
                    nv       = 1'b1;
                    if (!j.calm && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 13);
                end
            end
            in_valid <= nv;

            // receiver stalls in bursts
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm_now && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: log accepted inputs, check frames on the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        wvm_pkg::out_item_t want;
        cyc <= cyc + 1;
        took <= in_valid && in_ready;
        if (in_valid && in_ready && cur_job.has_frame)
            frames_due.push_back(cur_job.frame);
        if (out_valid && out_ready)
        begin
            if (frames_due.size() == 0)
            begin
                fail_cnt++;
                if (miss_cnt < MAX_MISS)
                    $display("unexpected frame: mix %0d mask %h",
                             out_item.mix_sample, out_item.playing_mask);
                miss_cnt++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (out_item.mix_sample !== want.mix_sample ||
                    out_item.playing_mask !== want.playing_mask)
                begin
                    fail_cnt++;
                    if (miss_cnt < MAX_MISS)
                        $display("frame mismatch: mix exp %0d got %0d, mask exp %h got %h",
                                 want.mix_sample, out_item.mix_sample,
                                 want.playing_mask, out_item.playing_mask);
                    miss_cnt++;
                end
            end
        end
        if (cyc >= MAX_CYC)
        begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: memory setup, directed cases, then random ops
    // ---------------------------------------------------------------
    initial
    begin
        wvm_pkg::in_item_t it;
        int                pick;
        bit                calm;
        int                n;

        unwritten_hit = '0;
        for (int i = 0; i < NV; i++)
        begin
            v_on[i] = 0; v_base[i] = 0; v_len[i] = 0; v_loop[i] = 0; v_loops[i] = 0;
            v_wide[i] = 0; v_pos[i] = 0; v_frac[i] = 0; v_step[i] = 0; v_gain[i] = 0;
        end

        // a block of words straddling the top of memory, with extreme values
        for (int a = 65528; a < 65536 + 16; a++)
        begin
            it          = noise_item();
            it.op       = wvm_pkg::OP_WRITE;
            it.addr     = 16'(a % 65536);
            case (a % 5)
                0: it.mem_word = 16'h7FFF;
                1: it.mem_word = 16'h8000;
                2: it.mem_word = 16'h0080;
                3: it.mem_word = 16'h7F81;
                default: ;
            endcase
            add_job(it, 1'b0, 1'b0);
        end

        // directed voice setups
        it = noise_item(); it.op = wvm_pkg::OP_START; it.voice = 4'd0; it.addr = 16'd0;
        it.sample_count = 18'd8; it.loop_on = 1'b0; it.sixteen_bit = 1'b1;
        it.phase_step = 24'h010000; it.volume = 7'd127;
        add_job(it, 1'b0, 1'b0);
        // 8-bit voice wrapping the top of memory, looping
        it = noise_item(); it.op = wvm_pkg::OP_START; it.voice = 4'd1; it.addr = 16'hFFFA;
        it.sample_count = 18'd16; it.loop_start = 17'd4; it.loop_on = 1'b1;
        it.sixteen_bit = 1'b0; it.phase_step = 24'h018000; it.volume = 7'd64;
        add_job(it, 1'b0, 1'b0);
        // zero length stays playing silently
        it = noise_item(); it.op = wvm_pkg::OP_START; it.voice = 4'd15;
        it.sample_count = 18'd0;
        add_job(it, 1'b0, 1'b0);
        // loop point at length behaves as one-shot
        it = noise_item(); it.op = wvm_pkg::OP_START; it.voice = 4'd2; it.addr = 16'hFFF8;
        it.sample_count = 18'd12; it.loop_start = 17'd12; it.loop_on = 1'b1;
        it.sixteen_bit = 1'b1; it.phase_step = 24'h02C000; it.volume = 7'd127;
        add_job(it, 1'b0, 1'b0);
        // zero volume
        it = noise_item(); it.op = wvm_pkg::OP_START; it.voice = 4'd3; it.addr = 16'd2;
        it.sample_count = 18'd10; it.loop_start = 17'd0; it.loop_on = 1'b1;
        it.sixteen_bit = 1'b1; it.phase_step = 24'h00C000; it.volume = 7'd0;
        add_job(it, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++)
            add_render(1'b0, 1'b0);
        // huge step/volume on an idle voice, zero step on voice 3, then stop voice 0
        it = noise_item(); it.op = wvm_pkg::OP_SET; it.voice = 4'd5;
        it.phase_step = 24'hFFFFFF; it.volume = 7'd127;
        add_job(it, 1'b0, 1'b0);
        it = noise_item(); it.op = wvm_pkg::OP_SET; it.voice = 4'd3;
        it.phase_step = 24'h000000; it.volume = 7'd127;
        add_job(it, 1'b0, 1'b0);
        it = noise_item(); it.op = wvm_pkg::OP_STOP; it.voice = 4'd0;
        add_job(it, 1'b0, 1'b0);
        for (int c = wvm_pkg::OP_RENDER + 1; c < 8; c++)
        begin
            it = noise_item(); it.op = 3'(c);
            add_job(it, 1'b0, 1'b0);
        end
        add_render(1'b1, 1'b0);

        // random part
        n = 0;
        while (pending_q.size() < N_ITEMS)
        begin
            calm = pending_q.size() > N_ITEMS - 60;
            pick = $urandom_range(0, 99);
            n++;
            if (pick < 38)
                add_render(n % 150 == 0, calm);
            else if (pick < 58)
            begin
                it    = noise_item();
                it.op = wvm_pkg::OP_WRITE;
                if ($urandom_range(0, 2) != 0)
                    it.addr = 16'($urandom_range(0, 300));
                add_job(it, 1'b0, calm);
            end
            else if (pick < 78)
                add_start(calm);
            else if (pick < 88)
            begin
                it    = noise_item();
                it.op = wvm_pkg::OP_SET;
                if ($urandom_range(0, 2) != 0)
                    it.phase_step = 24'($urandom_range(0, 24'h3FFFF));
                add_job(it, 1'b0, calm);
            end
            else if (pick < 95)
            begin
                it    = noise_item();
                it.op = wvm_pkg::OP_STOP;
                add_job(it, 1'b0, calm);
            end
            else
            begin
                it    = noise_item();
                it.op = 3'($urandom_range(wvm_pkg::OP_RENDER + 1, 7));
                add_job(it, 1'b0, calm);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !in_valid && frames_due.size() == 0);
        repeat (TAIL_CYC) @(posedge clk);
        if (fail_cnt == 0 && frames_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wvm_pkg.sv
hw/rtl/wvm_mod_unit.sv
hw/rtl/wavetable_voice_mixer.sv
hw/rtl/wvm_checker.sv
test/tb.sv
